[rtl/lrip_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrip_pkg
// Shared types, widths and constants of the lidar range image projector.
// ----------------------------------------------------------------------------
package lrip_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 1024;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 10;
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int MEM_DEPTH  = MAX_ROWS * MAX_COLS;

    localparam int RANGE_W    = 18;
    localparam int COORD_W    = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [RANGE_W-1:0] EMPTY_RANGE = 18'd262143;
    localparam logic [RANGE_W-1:0] RANGE_SAT   = 18'd262142;

    // Square root unit: 62-bit radicand, 31-bit root.
    localparam int SQ_W       = 62;
    localparam int SQ_STEPS   = 31;

    // Angle unit: vectoring rotations, accumulator in 1/32768 degree.
    localparam int CW           = 44;
    localparam int ACC_W        = 25;
    localparam int ANG_W        = 17;
    localparam int CORDIC_STEPS = 18;
    localparam logic signed [ACC_W-1:0] HALF_TURN = 25'sd5898240;

    // Divider: quotient of (2a+b)/(2b), which is a/b rounded.
    localparam int DIV_N      = 29;
    localparam int DIV_D      = 18;

    localparam int STEP_W     = 5;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_QUERY  = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VFOV_UPPER = 3'd0,
        CFG_VFOV_LOWER = 3'd1,
        CFG_HFOV       = 3'd2,
        CFG_ROWS       = 3'd3,
        CFG_COLS       = 3'd4,
        CFG_MAX_RANGE  = 3'd5
    } t_cfg_idx;

    function automatic logic signed [ACC_W-1:0] angle_tab(input logic [STEP_W-1:0] idx);
        logic signed [ACC_W-1:0] v;
        begin
            case (idx)
                5'd0:    v = 25'sd1474560;
                5'd1:    v = 25'sd870484;
                5'd2:    v = 25'sd459940;
                5'd3:    v = 25'sd233473;
                5'd4:    v = 25'sd117189;
                5'd5:    v = 25'sd58652;
                5'd6:    v = 25'sd29333;
                5'd7:    v = 25'sd14667;
                5'd8:    v = 25'sd7334;
                5'd9:    v = 25'sd3667;
                5'd10:   v = 25'sd1833;
                5'd11:   v = 25'sd917;
                5'd12:   v = 25'sd458;
                5'd13:   v = 25'sd229;
                5'd14:   v = 25'sd115;
                5'd15:   v = 25'sd57;
                5'd16:   v = 25'sd29;
                5'd17:   v = 25'sd14;
                default: v = 25'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

[rtl/lidar_range_image_projector_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_range_image_projector_top
// Spherical projection of lidar points into a range image with a
// nearest-range buffer, visibility queries and pixel reads.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low; its single result
// appears on the o_ result ports for exactly one cycle with o_valid high, and
// the receiver cannot stall it. Busy stays high for the whole operation.
// Insert and query run three squarings on the shared multiplier, two 31-pass
// square roots, two 18-pass angle rotations and two 29-pass divisions for row
// and column, then a memory read and a final step.
// A pixel read runs only the memory read and the final step. Clearing the image
// writes all 65536 pixels, one per cycle; the same clearing pass runs after
// reset, during which operations wait but configuration writes are taken.
// ----------------------------------------------------------------------------
module lidar_range_image_projector_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_operation,
    input  logic signed [lrip_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [lrip_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [lrip_pkg::COORD_W-1:0] i_point_z,
    input  logic [lrip_pkg::ROW_W-1:0]          i_pixel_row_sel,
    input  logic [lrip_pkg::COL_W-1:0]          i_pixel_col_sel,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lrip_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lrip_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_valid,
    output logic [lrip_pkg::ROW_W-1:0]          o_pixel_row,
    output logic [lrip_pkg::COL_W-1:0]          o_pixel_col,
    output logic [lrip_pkg::RANGE_W-1:0]        o_stored_range,
    output logic [lrip_pkg::RANGE_W-1:0]        o_point_range,
    output logic                                o_pixel_updated,
    output logic                                o_observed,
    output logic                                o_in_vfov
);

    typedef enum logic [17:0] {
        ST_IDLE   = 18'b000000000000000001,
        ST_CLEAR  = 18'b000000000000000010,
        ST_SQX    = 18'b000000000000000100,
        ST_SQY    = 18'b000000000000001000,
        ST_SQZ    = 18'b000000000000010000,
        ST_ROOT_S = 18'b000000000000100000,
        ST_RANGE  = 18'b000000000001000000,
        ST_ROOT_H = 18'b000000000010000000,
        ST_AZ_SET = 18'b000000000100000000,
        ST_CORD   = 18'b000000001000000000,
        ST_ANG    = 18'b000000010000000000,
        ST_MROW   = 18'b000000100000000000,
        ST_MCOL   = 18'b000001000000000000,
        ST_DSET   = 18'b000010000000000000,
        ST_DIV    = 18'b000100000000000000,
        ST_DFIN   = 18'b001000000000000000,
        ST_MEM    = 18'b010000000000000000,
        ST_FIN    = 18'b100000000000000000
    } t_state;

    localparam int CW  = lrip_pkg::CW;
    localparam int AW  = lrip_pkg::ACC_W;
    localparam int GW  = lrip_pkg::ANG_W;
    localparam int SW  = lrip_pkg::SQ_W;
    localparam int DN  = lrip_pkg::DIV_N;
    localparam int DD  = lrip_pkg::DIV_D;
    localparam int RW  = lrip_pkg::RANGE_W;
    localparam int XW  = lrip_pkg::COORD_W;

    // Control and configuration.
    t_state                       r_state, n_state;
    logic [lrip_pkg::STEP_W-1:0]  r_step, n_step;
    logic [lrip_pkg::ADDR_W-1:0]  r_clr_addr, n_clr_addr;
    logic                         r_clr_report, n_clr_report;
    logic                         r_do_el, n_do_el;
    logic                         r_do_col, n_do_col;
    logic                         r_valid, n_valid;

    logic signed [14:0]           r_vfov_upper;
    logic signed [14:0]           r_vfov_lower;
    logic [15:0]                  r_hfov;
    logic [6:0]                   r_rows;
    logic [10:0]                  r_cols;
    logic [RW-1:0]                r_max_range;

    // Operation payload and intermediate results.
    lrip_pkg::t_op                r_op, n_op;
    logic signed [XW-1:0]         r_x, n_x, r_y, n_y, r_z, n_z;
    logic [lrip_pkg::ROW_W-1:0]   r_row, n_row;
    logic [lrip_pkg::COL_W-1:0]   r_col, n_col;
    logic [39:0]                  r_hsq, n_hsq;
    logic [RW-1:0]                r_range, n_range;
    logic [29:0]                  r_h, n_h;
    logic signed [GW-1:0]         r_az, n_az, r_el, n_el;
    logic signed [41:0]           r_prod, n_prod;

    // Square root unit.
    logic [SW-1:0]                r_sq_n, n_sq_n, r_sq_r, n_sq_r, r_sq_b, n_sq_b;
    // Angle unit.
    logic signed [CW-1:0]         r_cx, n_cx, r_cy, n_cy;
    logic signed [AW-1:0]         r_acc, n_acc;
    logic                         r_czero, n_czero;
    // Divider.
    logic [DN-1:0]                r_dv_q, n_dv_q;
    logic [DD-1:0]                r_dv_rem, n_dv_rem, r_dv_v, n_dv_v;
    logic                         r_dv_neg, n_dv_neg;

    // Result registers.
    logic [lrip_pkg::ROW_W-1:0]   r_o_row, n_o_row;
    logic [lrip_pkg::COL_W-1:0]   r_o_col, n_o_col;
    logic [RW-1:0]                r_o_stored, n_o_stored, r_o_range, n_o_range;
    logic                         r_o_upd, n_o_upd, r_o_obs, n_o_obs, r_o_vfov, n_o_vfov;

    // Range image.
    logic [RW-1:0]                mem [0:lrip_pkg::MEM_DEPTH-1];
    logic [RW-1:0]                r_mem_q;
    logic                         mem_we;
    logic [lrip_pkg::ADDR_W-1:0]  mem_waddr;
    logic [RW-1:0]                mem_wdata;
    logic [lrip_pkg::ADDR_W-1:0]  mem_raddr;

    logic                         accept;
    logic [lrip_pkg::ROW_W-1:0]   rows_m1;
    logic [lrip_pkg::COL_W-1:0]   cols_m1;

    logic signed [20:0]           mul_a, mul_b;
    logic signed [41:0]           mul_p;
    logic signed [16:0]           row_diff;
    logic signed [18:0]           col_arg;

    logic [SW-1:0]                sq_trial;
    logic                         sq_ge;
    logic [20:0]                  root_rnd;

    logic signed [CW-1:0]         c_dx, c_dy, c_xin, c_yin;
    logic signed [AW-1:0]         c_tab;
    logic [AW-1:0]                acc_mag;
    logic [GW-1:0]                ang_mag;
    logic signed [GW-1:0]         ang_val;

    logic signed [DD-1:0]         dv_den;
    logic [41:0]                  dv_num_mag;
    logic [16:0]                  dv_den_mag;
    logic                         dv_den_zero;
    logic [DD:0]                  dv_trial;
    logic                         dv_ge;
    logic [DN-1:0]                dv_lim;
    logic [DN-1:0]                dv_res;

    logic                         fin_upd;
    logic                         fin_vfov;
    logic                         fin_obs;
    logic [21:0]                  range_x10, stored_x9;

    assign accept      = start && (r_state == ST_IDLE);
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign o_valid         = r_valid;
    assign o_pixel_row     = r_o_row;
    assign o_pixel_col     = r_o_col;
    assign o_stored_range  = r_o_stored;
    assign o_point_range   = r_o_range;
    assign o_pixel_updated = r_o_upd;
    assign o_observed      = r_o_obs;
    assign o_in_vfov       = r_o_vfov;

    // Effective image size, clamped to the store.
    always_comb begin
        if (r_rows == 7'd0) begin
            rows_m1 = '0;
        end else if (r_rows >= 7'(lrip_pkg::MAX_ROWS)) begin
            rows_m1 = 6'(lrip_pkg::MAX_ROWS - 1);
        end else begin
            rows_m1 = 6'(r_rows - 7'd1);
        end
        if (r_cols == 11'd0) begin
            cols_m1 = '0;
        end else if (r_cols >= 11'(lrip_pkg::MAX_COLS)) begin
            cols_m1 = 10'(lrip_pkg::MAX_COLS - 1);
        end else begin
            cols_m1 = 10'(r_cols - 11'd1);
        end
    end

    // Shared multiplier.
    assign row_diff = {{2{r_vfov_upper[14]}}, r_vfov_upper} - r_el;
    assign col_arg  = {{2{r_az[GW-1]}}, r_az} + {{2{r_az[GW-1]}}, r_az}
                    + {3'b000, r_hfov};

    always_comb begin
        case (r_state)
            ST_SQX: begin
                mul_a = {r_x[XW-1], r_x};
                mul_b = {r_x[XW-1], r_x};
            end
            ST_SQY: begin
                mul_a = {r_y[XW-1], r_y};
                mul_b = {r_y[XW-1], r_y};
            end
            ST_SQZ: begin
                mul_a = {r_z[XW-1], r_z};
                mul_b = {r_z[XW-1], r_z};
            end
            ST_MROW: begin
                mul_a = {15'd0, rows_m1};
                mul_b = {{4{row_diff[16]}}, row_diff};
            end
            ST_MCOL: begin
                mul_a = {11'd0, cols_m1};
                mul_b = {{2{col_arg[18]}}, col_arg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Square root pass.
    assign sq_trial = r_sq_r + r_sq_b;
    assign sq_ge    = (r_sq_n >= sq_trial);
    assign root_rnd = r_sq_r[20:0] + ((r_sq_n > r_sq_r) ? 21'd1 : 21'd0);

    // Angle rotation pass.
    assign c_dx  = r_cy >>> r_step;
    assign c_dy  = r_cx >>> r_step;
    assign c_tab = lrip_pkg::angle_tab(r_step);

    // Accumulator to 1/128 degree, rounded half away from zero.
    assign acc_mag = r_acc[AW-1] ? AW'(-r_acc) : AW'(r_acc);
    assign ang_mag = GW'((acc_mag + 25'd128) >> 8);
    assign ang_val = r_czero ? '0 : (r_acc[AW-1] ? -$signed(ang_mag) : $signed(ang_mag));

    // Operands for the angle unit: azimuth first, then elevation.
    always_comb begin
        if (r_state == ST_AZ_SET) begin
            c_xin = {{(CW-40){r_x[XW-1]}}, r_x, 20'd0};
            c_yin = {{(CW-40){r_y[XW-1]}}, r_y, 20'd0};
        end else begin
            c_xin = {{(CW-40){1'b0}}, r_h, 10'd0};
            c_yin = {{(CW-40){r_z[XW-1]}}, r_z, 20'd0};
        end
    end

    // Divider set-up and pass.
    assign dv_den = r_do_col ? {1'b0, r_hfov, 1'b0}
                             : ({{3{r_vfov_upper[14]}}, r_vfov_upper}
                                - {{3{r_vfov_lower[14]}}, r_vfov_lower});
    assign dv_num_mag  = r_prod[41] ? 42'(-r_prod) : 42'(r_prod);
    assign dv_den_mag  = dv_den[DD-1] ? 17'(-dv_den) : 17'(dv_den);
    assign dv_den_zero = r_do_col ? (r_hfov == 16'd0) : (dv_den == '0);
    assign dv_trial    = {r_dv_rem, r_dv_q[DN-1]};
    assign dv_ge       = (dv_trial >= {1'b0, r_dv_v});
    assign dv_lim      = r_do_col ? DN'(cols_m1) : DN'(rows_m1);

    always_comb begin
        if (r_dv_neg) begin
            dv_res = '0;
        end else if (r_dv_q > dv_lim) begin
            dv_res = dv_lim;
        end else begin
            dv_res = r_dv_q;
        end
    end

    // Final decisions.
    assign fin_vfov  = (r_el >= $signed({{2{r_vfov_lower[14]}}, r_vfov_lower}))
                    && (r_el <= $signed({{2{r_vfov_upper[14]}}, r_vfov_upper}));
    assign fin_upd   = (r_op == lrip_pkg::OP_INSERT) && (r_range < r_mem_q);
    assign range_x10 = {1'b0, r_range, 3'b000} + {3'b000, r_range, 1'b0};
    assign stored_x9 = {1'b0, r_mem_q, 3'b000} + {4'b0000, r_mem_q};
    assign fin_obs   = fin_vfov && (r_range <= r_max_range)
                    && !((r_mem_q != lrip_pkg::EMPTY_RANGE) && (range_x10 > stored_x9));

    // Memory ports.
    assign mem_raddr = {r_row, r_col};
    always_comb begin
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = lrip_pkg::EMPTY_RANGE;
        end else begin
            mem_we    = (r_state == ST_FIN) && fin_upd;
            mem_waddr = {r_row, r_col};
            mem_wdata = r_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= mem[mem_raddr];
    end

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_clr_addr   = r_clr_addr;
        n_clr_report = r_clr_report;
        n_do_el      = r_do_el;
        n_do_col     = r_do_col;
        n_valid      = 1'b0;
        n_op         = r_op;
        n_x          = r_x;
        n_y          = r_y;
        n_z          = r_z;
        n_row        = r_row;
        n_col        = r_col;
        n_hsq        = r_hsq;
        n_range      = r_range;
        n_h          = r_h;
        n_az         = r_az;
        n_el         = r_el;
        n_prod       = r_prod;
        n_sq_n       = r_sq_n;
        n_sq_r       = r_sq_r;
        n_sq_b       = r_sq_b;
        n_cx         = r_cx;
        n_cy         = r_cy;
        n_acc        = r_acc;
        n_czero      = r_czero;
        n_dv_q       = r_dv_q;
        n_dv_rem     = r_dv_rem;
        n_dv_v       = r_dv_v;
        n_dv_neg     = r_dv_neg;
        n_o_row      = r_o_row;
        n_o_col      = r_o_col;
        n_o_stored   = r_o_stored;
        n_o_range    = r_o_range;
        n_o_upd      = r_o_upd;
        n_o_obs      = r_o_obs;
        n_o_vfov     = r_o_vfov;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_op  = lrip_pkg::t_op'(i_operation);
                    n_x   = i_point_x;
                    n_y   = i_point_y;
                    n_z   = i_point_z;
                    n_row = i_pixel_row_sel;
                    n_col = i_pixel_col_sel;
                    case (lrip_pkg::t_op'(i_operation))
                        lrip_pkg::OP_CLEAR: begin
                            n_clr_addr   = '0;
                            n_clr_report = 1'b1;
                            n_state      = ST_CLEAR;
                        end
                        lrip_pkg::OP_READ: begin
                            n_state = ST_MEM;
                        end
                        default: begin
                            n_state = ST_SQX;
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    if (r_clr_report) begin
                        n_valid    = 1'b1;
                        n_o_row    = '0;
                        n_o_col    = '0;
                        n_o_stored = '0;
                        n_o_range  = '0;
                        n_o_upd    = 1'b0;
                        n_o_obs    = 1'b0;
                        n_o_vfov   = 1'b0;
                    end
                    n_clr_report = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            ST_SQX: begin
                n_hsq   = mul_p[39:0];
                n_state = ST_SQY;
            end
            ST_SQY: begin
                n_hsq   = r_hsq + mul_p[39:0];
                n_state = ST_SQZ;
            end
            ST_SQZ: begin
                n_sq_n  = SW'(r_hsq) + SW'(mul_p[39:0]);
                n_sq_r  = '0;
                n_sq_b  = SW'(1) << (SW - 2);
                n_step  = '0;
                n_state = ST_ROOT_S;
            end
            ST_ROOT_S, ST_ROOT_H: begin
                if (sq_ge) begin
                    n_sq_n = r_sq_n - sq_trial;
                    n_sq_r = (r_sq_r >> 1) + r_sq_b;
                end else begin
                    n_sq_r = r_sq_r >> 1;
                end
                n_sq_b = r_sq_b >> 2;
                n_step = r_step + 1'b1;
                if (r_step == 5'(lrip_pkg::SQ_STEPS - 1)) begin
                    n_state = (r_state == ST_ROOT_S) ? ST_RANGE : ST_AZ_SET;
                end
            end
            ST_RANGE: begin
                // Range rounded to the nearest millimeter from the remainder.
                n_range = (root_rnd > 21'(lrip_pkg::RANGE_SAT))
                        ? lrip_pkg::RANGE_SAT : root_rnd[RW-1:0];
                n_sq_n  = {2'b00, r_hsq, 20'd0};
                n_sq_r  = '0;
                n_sq_b  = SW'(1) << (SW - 2);
                n_step  = '0;
                n_state = ST_ROOT_H;
            end
            ST_AZ_SET: begin
                n_h     = r_sq_r[29:0];
                n_do_el = 1'b0;
                n_czero = (c_xin == '0) && (c_yin == '0);
                if (c_xin < 0) begin
                    n_acc = (c_yin >= 0) ? lrip_pkg::HALF_TURN : -lrip_pkg::HALF_TURN;
                    n_cx  = -c_xin;
                    n_cy  = -c_yin;
                end else begin
                    n_acc = '0;
                    n_cx  = c_xin;
                    n_cy  = c_yin;
                end
                n_step  = '0;
                n_state = ST_CORD;
            end
            ST_CORD: begin
                if (!r_cy[CW-1]) begin
                    n_cx  = r_cx + c_dx;
                    n_cy  = r_cy - c_dy;
                    n_acc = r_acc + c_tab;
                end else begin
                    n_cx  = r_cx - c_dx;
                    n_cy  = r_cy + c_dy;
                    n_acc = r_acc - c_tab;
                end
                n_step = r_step + 1'b1;
                if (r_step == 5'(lrip_pkg::CORDIC_STEPS - 1)) begin
                    n_state = ST_ANG;
                end
            end
            ST_ANG: begin
                if (!r_do_el) begin
                    // Azimuth done; the elevation input never has a negative x.
                    n_az    = ang_val;
                    n_do_el = 1'b1;
                    n_czero = (c_xin == '0) && (c_yin == '0);
                    n_acc   = '0;
                    n_cx    = c_xin;
                    n_cy    = c_yin;
                    n_step  = '0;
                    n_state = ST_CORD;
                end else begin
                    n_el    = ang_val;
                    n_state = ST_MROW;
                end
            end
            ST_MROW: begin
                n_prod   = mul_p;
                n_do_col = 1'b0;
                n_state  = ST_DSET;
            end
            ST_MCOL: begin
                n_prod   = mul_p;
                n_do_col = 1'b1;
                n_state  = ST_DSET;
            end
            ST_DSET: begin
                n_dv_neg = r_prod[41] ^ dv_den[DD-1];
                n_dv_q   = DN'({dv_num_mag[27:0], 1'b0}) + DN'(dv_den_mag);
                n_dv_v   = {dv_den_mag, 1'b0};
                n_dv_rem = '0;
                n_step   = '0;
                if (dv_den_zero) begin
                    // A zero-width field of view maps everything to index zero.
                    if (r_do_col) begin
                        n_col   = '0;
                        n_state = ST_MEM;
                    end else begin
                        n_row   = '0;
                        n_state = ST_MCOL;
                    end
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_dv_rem = dv_ge ? DD'(dv_trial - {1'b0, r_dv_v}) : dv_trial[DD-1:0];
                n_dv_q   = {r_dv_q[DN-2:0], dv_ge};
                n_step   = r_step + 1'b1;
                if (r_step == 5'(DN - 1)) begin
                    n_state = ST_DFIN;
                end
            end
            ST_DFIN: begin
                if (r_do_col) begin
                    n_col   = dv_res[lrip_pkg::COL_W-1:0];
                    n_state = ST_MEM;
                end else begin
                    n_row   = dv_res[lrip_pkg::ROW_W-1:0];
                    n_state = ST_MCOL;
                end
            end
            ST_MEM: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                n_valid    = 1'b1;
                n_o_row    = r_row;
                n_o_col    = r_col;
                n_o_stored = fin_upd ? r_range : r_mem_q;
                if (r_op == lrip_pkg::OP_READ) begin
                    n_o_range = '0;
                    n_o_upd   = 1'b0;
                    n_o_obs   = 1'b0;
                    n_o_vfov  = 1'b0;
                end else begin
                    n_o_range = r_range;
                    n_o_upd   = fin_upd;
                    n_o_obs   = (r_op == lrip_pkg::OP_QUERY) && fin_obs;
                    n_o_vfov  = fin_vfov;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state; the clearing pass starts right out of reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_clr_report <= 1'b0;
            r_valid      <= 1'b0;
            r_step       <= '0;
            r_do_el      <= 1'b0;
            r_do_col     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_clr_report <= n_clr_report;
            r_valid      <= n_valid;
            r_step       <= n_step;
            r_do_el      <= n_do_el;
            r_do_col     <= n_do_col;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vfov_upper <= 15'sd2880;
            r_vfov_lower <= -15'sd2880;
            r_hfov       <= 16'd46080;
            r_rows       <= 7'd32;
            r_cols       <= 11'd360;
            r_max_range  <= 18'd80000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                lrip_pkg::CFG_VFOV_UPPER: r_vfov_upper <= i_cfg_data[14:0];
                lrip_pkg::CFG_VFOV_LOWER: r_vfov_lower <= i_cfg_data[14:0];
                lrip_pkg::CFG_HFOV:       r_hfov       <= i_cfg_data[15:0];
                lrip_pkg::CFG_ROWS:       r_rows       <= i_cfg_data[6:0];
                lrip_pkg::CFG_COLS:       r_cols       <= i_cfg_data[10:0];
                lrip_pkg::CFG_MAX_RANGE:  r_max_range  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_x        <= n_x;
        r_y        <= n_y;
        r_z        <= n_z;
        r_row      <= n_row;
        r_col      <= n_col;
        r_hsq      <= n_hsq;
        r_range    <= n_range;
        r_h        <= n_h;
        r_az       <= n_az;
        r_el       <= n_el;
        r_prod     <= n_prod;
        r_sq_n     <= n_sq_n;
        r_sq_r     <= n_sq_r;
        r_sq_b     <= n_sq_b;
        r_cx       <= n_cx;
        r_cy       <= n_cy;
        r_acc      <= n_acc;
        r_czero    <= n_czero;
        r_dv_q     <= n_dv_q;
        r_dv_rem   <= n_dv_rem;
        r_dv_v     <= n_dv_v;
        r_dv_neg   <= n_dv_neg;
        r_o_row    <= n_o_row;
        r_o_col    <= n_o_col;
        r_o_stored <= n_o_stored;
        r_o_range  <= n_o_range;
        r_o_upd    <= n_o_upd;
        r_o_obs    <= n_o_obs;
        r_o_vfov   <= n_o_vfov;
    end

endmodule
